### sv/websocket_frame_deframer_assert.svh
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define WSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is low.
`define WSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### sv/wsd_pkg.sv
package wsd_pkg;

  localparam int LEN_W = 63;

  localparam logic [6:0] LEN_CODE_16    = 7'd126;
  localparam logic [6:0] LEN_CODE_64    = 7'd127;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic [3:0]       opcode;
    logic             fin;
    logic [LEN_W-1:0] frame_length;
    logic             last;
    logic             empty_res;
  } wsd_res_t;

endpackage

### sv/wsd_parser.sv
module wsd_parser
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] data_byte,
  output logic       res_vld,
  output wsd_res_t   res
);

  phase_t           phase_r, phase_nxt;
  logic [4:0]       hdr_bits_r, hdr_bits_nxt;
  logic             masked_r, masked_nxt;
  logic [3:0]       left_r, left_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [1:0]       pos_r, pos_nxt;

  logic             len_fin;
  logic             hdr_done;
  logic             msk;
  logic [LEN_W-1:0] len_val;
  logic [7:0]       key_byte;

  always_comb begin
    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    hdr_bits_nxt = hdr_bits_r;
    masked_nxt   = masked_r;
    left_nxt     = left_r;
    len_nxt      = len_r;
    key_nxt      = key_r;
    rem_nxt      = rem_r;
    pos_nxt      = pos_r;
    len_fin      = 1'b0;
    hdr_done     = 1'b0;
    msk          = masked_r;
    len_val      = len_r;
    res_vld      = 1'b0;
    res.payload_byte = 8'd0;
    res.opcode       = hdr_bits_r[3:0];
    res.fin          = hdr_bits_r[4];
    res.frame_length = len_r;
    res.last         = 1'b0;
    res.empty_res    = 1'b0;

    if (step_en) begin
      case (phase_r)
        PH_HDR1: begin
          msk        = data_byte[7];
          masked_nxt = data_byte[7];
          if (data_byte[6:0] == LEN_CODE_16) begin
            left_nxt  = EXT16_BYTES;
            len_nxt   = '0;
            phase_nxt = PH_EXTLEN;
          end else if (data_byte[6:0] == LEN_CODE_64) begin
            left_nxt  = EXT64_BYTES;
            len_nxt   = '0;
            phase_nxt = PH_EXTLEN;
          end else begin
            len_val = {{(LEN_W-7){1'b0}}, data_byte[6:0]};
            len_fin = 1'b1;
          end
        end
        PH_EXTLEN: begin
          len_val  = {len_r[LEN_W-9:0], data_byte};
          len_nxt  = len_val;
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            len_fin = 1'b1;
          end
        end
        PH_KEY: begin
          key_nxt  = {key_r[23:0], data_byte};
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          res_vld          = 1'b1;
          res.payload_byte = data_byte ^ key_byte;
          res.last         = (rem_r == {{(LEN_W-1){1'b0}}, 1'b1});
          rem_nxt          = rem_r - {{(LEN_W-1){1'b0}}, 1'b1};
          pos_nxt          = pos_r + 2'd1;
          if (res.last) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          hdr_bits_nxt = {data_byte[7], data_byte[3:0]};
          phase_nxt    = PH_HDR1;
        end
      endcase

      if (len_fin) begin
        len_nxt = len_val;
        key_nxt = '0;
        if (msk) begin
          left_nxt  = MASK_KEY_BYTES;
          phase_nxt = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        rem_nxt = len_val;
        pos_nxt = 2'd0;
        if (len_val == '0) begin
          res_vld          = 1'b1;
          res.last         = 1'b1;
          res.empty_res    = 1'b1;
          res.frame_length = len_val;
          phase_nxt        = PH_HDR0;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      hdr_bits_r <= '0;
      masked_r   <= 1'b0;
      left_r     <= '0;
      len_r      <= '0;
      key_r      <= '0;
      rem_r      <= '0;
      pos_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_bits_r <= hdr_bits_nxt;
      masked_r   <= masked_nxt;
      left_r     <= left_nxt;
      len_r      <= len_nxt;
      key_r      <= key_nxt;
      rem_r      <= rem_nxt;
      pos_r      <= pos_nxt;
    end
  end

endmodule

### sv/wsd_out_stage.sv
module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_vld,
  input  wsd_res_t res,
  input  logic     out_ready,
  output logic     adv,
  output logic     out_valid,
  output wsd_res_t out_res
);

  logic     vld_r;
  wsd_res_t res_r;

  assign adv       = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      res_r <= res;
    end
  end

endmodule

### sv/websocket_frame_deframer.sv
// A byte is held in the input register, its result in the output register.
// Throughput: one byte per cycle unless stalled; single header/payload parser stage.
// Empty frames give their one result on the byte that completes the header.
// Reset: synchronous, active low; the parser waits for a first header byte and
// both the input and output registers are emptied.
`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_payload_byte,
  output logic [3:0]       out_opcode,
  output logic             out_fin,
  output logic [LEN_W-1:0] out_frame_length,
  output logic             out_last,
  output logic             out_empty_res
);

  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       adv;
  logic       res_vld;
  wsd_res_t   res;
  wsd_res_t   out_res;

  assign in_ready = adv || !in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_data_byte;
    end
  end

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_vld_r && adv),
    .data_byte (byte_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .out_ready (out_ready),
    .adv       (adv),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_payload_byte = out_res.payload_byte;
  assign out_opcode       = out_res.opcode;
  assign out_fin          = out_res.fin;
  assign out_frame_length = out_res.frame_length;
  assign out_last         = out_res.last;
  assign out_empty_res    = out_res.empty_res;

  `WSD_ASSERT_IMP(a_empty_is_last, clk, rst_n, out_valid && out_empty_res, out_last && (out_payload_byte == 8'd0))
  `WSD_ASSERT_IMP(a_payload_len_nonzero, clk, rst_n, out_valid && !out_empty_res, out_frame_length != '0)
  `WSD_ASSERT_NXT(a_stalled_byte_held, clk, rst_n, in_vld_r && !adv, in_vld_r && $stable(byte_r))

endmodule
